// ===== rtl/core/range_table_union_and_membership_core_assert.svh =====
// Assertion macros for the range table core.
// Used by the top level; expects clk and arst_n in scope.
`ifndef RANGE_TABLE_UNION_AND_MEMBERSHIP_CORE_ASSERT_SVH
`define RANGE_TABLE_UNION_AND_MEMBERSHIP_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define RTUM_ASSERT(name, prop) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error("rtum assertion failed");
`define RTUM_NEVER(name, expr) \
	name: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
	else $error("rtum forbidden condition");
`else
`define RTUM_ASSERT(name, prop)
`define RTUM_NEVER(name, expr)
`endif
`endif

// ===== rtl/core/rtum_pkg.sv =====
// Shared types and codes for the range table core.
// No dependencies.
package rtum_pkg;
	localparam int MAX_RANGES_DEF = 256;

	typedef enum logic [1:0] {
		CMD_CLEAR  = 2'd0,
		CMD_ADD    = 2'd1,
		CMD_MEMBER = 2'd2,
		CMD_TOTAL  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_FULL = 2'd1,
		ST_BAD  = 2'd2
	} status_t;

	typedef struct packed {
		logic insert;
		logic rotate;
	} cell_ctl_t;

	typedef struct packed {
		logic init;
		logic step;
		logic tail;
		logic sum;
	} mrg_ctl_t;
endpackage

// ===== rtl/core/rtum_cell.sv =====
// One slot of the sorted range chain: sorted insert and circular rotate.
// Depends on rtum_pkg.
module rtum_cell import rtum_pkg::*; (
	input  logic        clk,
	input  cell_ctl_t   ctl,
	input  logic        slot_valid,
	input  logic        take_prev,
	input  logic [63:0] new_lo,
	input  logic [63:0] new_hi,
	input  logic [63:0] prev_lo,
	input  logic [63:0] prev_hi,
	input  logic [63:0] next_lo,
	input  logic [63:0] next_hi,
	output logic        take,
	output logic [63:0] lo,
	output logic [63:0] hi
);
	logic [63:0] lo_q, hi_q;

	// slot is taken by the new range or the one shifting in from below
	assign take = !slot_valid || (lo_q > new_lo);
	assign lo = lo_q;
	assign hi = hi_q;

	always_ff @(posedge clk) begin
		if (ctl.insert && take) begin
			lo_q <= take_prev ? prev_lo : new_lo;
			hi_q <= take_prev ? prev_hi : new_hi;
		end else if (ctl.rotate) begin
			lo_q <= next_lo;
			hi_q <= next_hi;
		end
	end
endmodule

// ===== rtl/core/rtum_merge.sv =====
// Head unit: membership test and union merge over ranges in ascending order.
// Depends on rtum_pkg.
module rtum_merge import rtum_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  mrg_ctl_t    ctl,
	input  logic [63:0] lo,
	input  logic [63:0] hi,
	input  logic [63:0] query,
	output logic        hit,
	output logic [63:0] total
);
	localparam logic [64:0] SAT = {1'b1, 64'd0};

	logic        first_q, hit_q;
	logic [63:0] cur_lo_q, cur_hi_q;
	logic [64:0] pend_q, acc_q;
	logic [65:0] sum;
	logic [64:0] acc_next, cur_len;

	assign cur_len = {1'b0, cur_hi_q} - {1'b0, cur_lo_q} + 65'd1;
	assign sum = {1'b0, acc_q} + {1'b0, pend_q};
	assign acc_next = (sum[65] || (sum[64] && |sum[63:0])) ? SAT : sum[64:0];
	assign hit = hit_q;
	assign total = acc_q[64] ? {64{1'b1}} : acc_q[63:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q  <= 1'b1;
			hit_q    <= 1'b0;
			pend_q   <= '0;
			acc_q    <= '0;
			cur_lo_q <= '0;
			cur_hi_q <= '0;
		end else if (ctl.init) begin
			first_q <= 1'b1;
			hit_q   <= 1'b0;
			pend_q  <= '0;
			acc_q   <= '0;
		end else if (ctl.step) begin
			acc_q <= acc_next;
			if (query >= lo && query <= hi)
				hit_q <= 1'b1;
			if (first_q) begin
				first_q  <= 1'b0;
				cur_lo_q <= lo;
				cur_hi_q <= hi;
				pend_q   <= '0;
			end else if (lo <= cur_hi_q) begin
				if (hi > cur_hi_q)
					cur_hi_q <= hi;
				pend_q <= '0;
			end else begin
				// disjoint: close current span; its length waits in pend_q for the accumulator
				pend_q   <= cur_len;
				cur_lo_q <= lo;
				cur_hi_q <= hi;
			end
		end else if (ctl.tail) begin
			acc_q  <= acc_next;
			pend_q <= first_q ? 65'd0 : cur_len;
		end else if (ctl.sum) begin
			acc_q  <= acc_next;
			pend_q <= '0;
		end
	end
endmodule

// ===== rtl/core/range_table_union_and_membership_core.sv =====
// Range table core: sorted chain of range cells with a merge unit at the head.
// Depends on rtum_pkg, rtum_cell, rtum_merge and the assertion header.
//
// Usage: drive command and operands with start high while busy is low; that
// edge accepts the transaction. Each transaction returns exactly one result,
// shown on status, hit and covered_total for one cycle with done high.
// Clear and add: result in the cycle after acceptance, busy stays low; a
// valid add to a non-full table goes straight into its sorted place in the chain.
// Membership query: the chain rotates once round all MAX_RANGES cells past
// the head comparator, then the emit state registers the result.
// Total query: the same rotation feeds the merge unit, then the tail and sum
// states fold the last span in before the emit state registers the result.
// The rotation length, one cell per cycle, sets the query rate.
// Reset empties the table (count to zero) and returns to idle; the cell
// contents need no clearing. Results cannot be stalled: done is a strobe.
`include "range_table_union_and_membership_core_assert.svh"
module range_table_union_and_membership_core import rtum_pkg::*; #(
	parameter int MAX_RANGES = MAX_RANGES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  command,
	input  logic [63:0] range_low,
	input  logic [63:0] range_high,
	input  logic [63:0] query_value,
	output logic        done,
	output logic [1:0]  status,
	output logic        hit,
	output logic [63:0] covered_total
);
	localparam int CNT_W = $clog2(MAX_RANGES + 1);
	localparam int IDX_W = $clog2(MAX_RANGES);
	localparam logic [IDX_W-1:0] LAST = IDX_W'(MAX_RANGES - 1);

	typedef enum logic [2:0] {S_IDLE, S_ROT, S_TAIL, S_SUM, S_EMIT} state_t;

	state_t            state_q;
	logic [CNT_W-1:0]  count_q;
	logic [IDX_W-1:0]  k_q;
	logic [63:0]       query_q;
	logic              total_cmd_q;
	logic              done_q, hit_q;
	logic [1:0]        status_q;
	logic [63:0]       total_q;

	logic              accept, add_ok;
	cell_ctl_t         cctl;
	mrg_ctl_t          mctl;
	logic [63:0]       lo_w [MAX_RANGES];
	logic [63:0]       hi_w [MAX_RANGES];
	logic              take_w [MAX_RANGES];
	logic              m_hit;
	logic [63:0]       m_total;

	assign accept = start && !busy;
	assign busy   = (state_q != S_IDLE);
	assign add_ok = accept && (command == CMD_ADD) && (range_low <= range_high)
		&& (count_q != CNT_W'(MAX_RANGES));

	assign cctl.insert = add_ok;
	assign cctl.rotate = (state_q == S_ROT);
	assign mctl.init = accept && (command == CMD_MEMBER || command == CMD_TOTAL);
	assign mctl.step = (state_q == S_ROT) && (CNT_W'(k_q) < count_q);
	assign mctl.tail = (state_q == S_TAIL);
	assign mctl.sum  = (state_q == S_SUM);

	for (genvar i = 0; i < MAX_RANGES; i++) begin : g_cell
		rtum_cell u_cell (
			.clk        (clk),
			.ctl        (cctl),
			.slot_valid (CNT_W'(i) < count_q),
			.take_prev  ((i == 0) ? 1'b0 : take_w[(i == 0) ? 0 : i - 1]),
			.new_lo     (range_low),
			.new_hi     (range_high),
			.prev_lo    (lo_w[(i == 0) ? 0 : i - 1]),
			.prev_hi    (hi_w[(i == 0) ? 0 : i - 1]),
			.next_lo    (lo_w[(i + 1) % MAX_RANGES]),
			.next_hi    (hi_w[(i + 1) % MAX_RANGES]),
			.take       (take_w[i]),
			.lo         (lo_w[i]),
			.hi         (hi_w[i])
		);
	end

	rtum_merge u_merge (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mctl),
		.lo     (lo_w[0]),
		.hi     (hi_w[0]),
		.query  (query_q),
		.hit    (m_hit),
		.total  (m_total)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			k_q         <= '0;
			total_cmd_q <= 1'b0;
			done_q      <= 1'b0;
			status_q    <= ST_OK;
			hit_q       <= 1'b0;
			total_q     <= '0;
			query_q     <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						status_q <= ST_OK;
						hit_q    <= 1'b0;
						total_q  <= '0;
						case (command)
							CMD_CLEAR: begin
								count_q <= '0;
								done_q  <= 1'b1;
							end
							CMD_ADD: begin
								done_q <= 1'b1;
								if (range_low > range_high)
									status_q <= ST_BAD;
								else if (count_q == CNT_W'(MAX_RANGES))
									status_q <= ST_FULL;
								else
									count_q <= count_q + CNT_W'(1);
							end
							default: begin
								query_q     <= query_value;
								total_cmd_q <= (command == CMD_TOTAL);
								k_q         <= '0;
								state_q     <= S_ROT;
							end
						endcase
					end
				end
				S_ROT: begin
					k_q <= k_q + IDX_W'(1);
					if (k_q == LAST)
						state_q <= total_cmd_q ? S_TAIL : S_EMIT;
				end
				S_TAIL: state_q <= S_SUM;
				S_SUM:  state_q <= S_EMIT;
				S_EMIT: begin
					done_q  <= 1'b1;
					hit_q   <= total_cmd_q ? 1'b0 : m_hit;
					total_q <= total_cmd_q ? m_total : 64'd0;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign done          = done_q;
	assign status        = status_q;
	assign hit           = hit_q;
	assign covered_total = total_q;

	`RTUM_ASSERT(a_count_bound, count_q <= CNT_W'(MAX_RANGES))
	`RTUM_ASSERT(a_accept_answers, accept |=> (done || busy))
	`RTUM_ASSERT(a_rot_exit, (state_q == S_ROT && k_q == LAST) |=> (state_q != S_ROT))
	`RTUM_NEVER(a_insert_busy, cctl.insert && busy)
endmodule
